FILE: src/plst_pkg.sv
// Shared types and constants for the positional list store.
// Used by positional_list_store_top; no other dependencies.
package plst_pkg;

   // Default list capacity (elements).
   localparam int CAPACITY_DEF = 32;

   // Request and response field widths.
   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 6;
   localparam int STAT_W  = 2;

   // Bus widths, fields packed from bit 0 and padded to whole bytes.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // Width for position checks; covers length + 1 up to capacity 64 plus one.
   localparam int CMP_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_DEL_HEAD = 3'd2,
      OP_DEL_TAIL = 3'd3,
      OP_INS_AT   = 3'd4,
      OP_DEL_AT   = 3'd5,
      OP_DUMP     = 3'd6,
      OP_NONE     = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_RD,
      S_DEL_WR,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_DONE
   } state_type;

endpackage

FILE: src/positional_list_store_top.sv
// Positional list store: bounded ordered list of signed 32-bit values in one
// memory, shifted one element at a time by a small sequencer.
// Depends on plst_pkg.
//
//   Channel   Dir   Payload (low bit first)                         Marker
//   req_*     in    operation[2:0] value[34:3] position[40:35]      -
//   rsp_*     out   element[31:0] count[37:32] status[39:38]        tlast
//
// Each request is finished before the next is accepted. Insert shifts elements from the
// tail down to 0-based index i, then writes the value; delete shifts elements above i down
// by one; dump sends one response per element; rejected or no-op requests get one response.
// Each shift step is a memory read followed by a write; req_tready is high only in idle.
// Synchronous active-high reset empties the list; cell contents are not cleared.
// A stalled response holds in the output register and the sequencer waits.
module positional_list_store_top
   import plst_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // operation, value, position, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // element, count, status
   output logic                  rsp_tlast
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W = $clog2(CAPACITY + 1);

   // Request fields
   op_type                      req_op;
   logic signed [VALUE_W-1:0]   req_value;
   logic [POS_W-1:0]            req_pos;

   // Sequencer and datapath registers
   state_type                   state_ff, state_in;
   logic [LEN_W-1:0]            length_ff, length_in;
   logic [IDX_W-1:0]            ptr_ff, ptr_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic signed [VALUE_W-1:0]   value_ff, value_in;
   status_type                  stat_ff, stat_in;

   // Memory
   logic [VALUE_W-1:0]          mem [CAPACITY];
   logic [VALUE_W-1:0]          rd_data_ff;
   logic [IDX_W-1:0]            rd_addr;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [VALUE_W-1:0]          wr_data;

   // Response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]   rsp_elem_ff, rsp_elem_in;
   logic [COUNT_W-1:0]          rsp_count_ff, rsp_count_in;
   status_type                  rsp_stat_ff, rsp_stat_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_load;
   logic                        out_free;

   // Request decode helpers
   logic [CMP_W-1:0]            len_c;
   logic [CMP_W-1:0]            pos1;
   logic                        is_ins;
   logic                        is_del;
   logic                        ptr_at_end;
   logic                        dump_last;

   assign req_op    = op_type'(req_tdata[OP_W-1:0]);
   assign req_value = req_tdata[OP_W +: VALUE_W];
   assign req_pos   = req_tdata[OP_W+VALUE_W +: POS_W];

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign len_c      = CMP_W'(length_ff);

   // Delete walk ends when the next source would be past the last element
   assign ptr_at_end = ((LEN_W'(ptr_ff) + LEN_W'(1)) >= length_ff);
   assign dump_last  = ((LEN_W'(ptr_ff) + LEN_W'(1)) == length_ff);

   // 1-based target position for the incoming request
   always_comb begin
      is_ins = 1'b0;
      is_del = 1'b0;
      pos1   = CMP_W'(req_pos);
      unique case (req_op)
         OP_INS_HEAD: begin
            is_ins = 1'b1;
            pos1   = CMP_W'(1);
         end
         OP_INS_TAIL: begin
            is_ins = 1'b1;
            pos1   = len_c + CMP_W'(1);
         end
         OP_INS_AT: begin
            is_ins = 1'b1;
         end
         OP_DEL_HEAD: begin
            is_del = 1'b1;
            pos1   = CMP_W'(1);
         end
         OP_DEL_TAIL: begin
            is_del = 1'b1;
            pos1   = len_c;
         end
         OP_DEL_AT: begin
            is_del = 1'b1;
         end
         default: begin
            is_ins = 1'b0;
         end
      endcase
   end

   // Next state and sequencer registers
   always_comb begin
      state_in  = state_ff;
      length_in = length_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      value_in  = value_ff;
      stat_in   = stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               value_in = req_value;
               idx_in   = IDX_W'(pos1 - CMP_W'(1));
               stat_in  = STAT_OK;
               state_in = S_DONE;
               if (is_ins) begin
                  if (pos1 < CMP_W'(1) || pos1 > len_c + CMP_W'(1)) begin
                     stat_in = STAT_INVALID;
                  end else if (len_c >= CMP_W'(CAPACITY)) begin
                     stat_in = STAT_FULL;
                  end else begin
                     ptr_in   = IDX_W'(length_ff);
                     state_in = S_INS_RD;
                  end
               end else if (is_del) begin
                  if (length_ff == '0) begin
                     stat_in = STAT_EMPTY;
                  end else if (pos1 < CMP_W'(1) || pos1 > len_c) begin
                     stat_in = STAT_INVALID;
                  end else begin
                     ptr_in   = IDX_W'(pos1 - CMP_W'(1));
                     state_in = S_DEL_RD;
                  end
               end else if (req_op == OP_DUMP) begin
                  if (length_ff == '0) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     ptr_in   = '0;
                     state_in = S_DUMP_RD;
                  end
               end else begin
                  stat_in = STAT_INVALID;
               end
            end
         end
         S_INS_RD: begin
            state_in = (ptr_ff == idx_ff) ? S_INS_PUT : S_INS_WR;
         end
         S_INS_WR: begin
            ptr_in   = ptr_ff - IDX_W'(1);
            state_in = S_INS_RD;
         end
         S_INS_PUT: begin
            length_in = length_ff + LEN_W'(1);
            state_in  = S_DONE;
         end
         S_DEL_RD: begin
            if (ptr_at_end) begin
               length_in = length_ff - LEN_W'(1);
               state_in  = S_DONE;
            end else begin
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            ptr_in   = ptr_ff + IDX_W'(1);
            state_in = S_DEL_RD;
         end
         S_DUMP_RD: begin
            state_in = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            if (out_free) begin
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + IDX_W'(1);
                  state_in = S_DUMP_RD;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory controls and response loading
   always_comb begin
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = rd_data_ff;
      rsp_load     = 1'b0;
      rsp_elem_in  = '0;
      rsp_stat_in  = stat_ff;
      rsp_last_in  = 1'b1;
      rsp_count_in = COUNT_W'(length_ff);
      unique case (state_ff)
         S_INS_RD: begin
            rd_addr = ptr_ff - IDX_W'(1);
         end
         S_INS_WR: begin
            wr_en = 1'b1;
         end
         S_INS_PUT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = value_ff;
         end
         S_DEL_RD: begin
            rd_addr = ptr_ff + IDX_W'(1);
         end
         S_DEL_WR: begin
            wr_en = 1'b1;
         end
         S_DUMP_OUT: begin
            rsp_load    = out_free;
            rsp_elem_in = rd_data_ff;
            rsp_stat_in = STAT_OK;
            rsp_last_in = dump_last;
         end
         S_DONE: begin
            rsp_load = out_free;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Response register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      idx_ff   <= idx_in;
      value_ff <= value_in;
      stat_ff  <= stat_in;
      if (rsp_load) begin
         rsp_elem_ff  <= rsp_elem_in;
         rsp_count_ff <= rsp_count_in;
         rsp_stat_ff  <= rsp_stat_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Cell memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_stat_ff, rsp_count_ff, rsp_elem_ff};

endmodule
